// ===== rtl/adjacency_text_parser_checker_defines.svh =====
// assertion macros shared by the checker rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ADJACENCY_TEXT_PARSER_CHECKER_DEFINES_SVH
`define ADJACENCY_TEXT_PARSER_CHECKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ATPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ATPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/atpc_pkg.sv =====
// types and constants of the adjacency text parser checker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package atpc_pkg;

  localparam int unsigned MAX_NODES   = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned NUM_W  = 31;
  localparam int unsigned LINE_W = 17;
  localparam int unsigned CNT_W  = 32;

  localparam logic [NUM_W-1:0]  NUM_MAX  = {NUM_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // node limit clamp, folded into the line width
  localparam logic [LINE_W-1:0] NODE_CAP =
    (MAX_NODES > int'(LINE_MAX)) ? LINE_MAX : LINE_W'(MAX_NODES);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // config register indexes
  localparam logic REG_WEIGHTED   = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  // input kind codes
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_FIRST    = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_DECREASE = 3'd5;
  localparam logic [2:0] ST_WEIGHTS  = 3'd6;
  localparam logic [2:0] ST_LINES    = 3'd7;

  // abort codes, same values as the matching status codes
  localparam logic [1:0] AB_NONE     = 2'd0;
  localparam logic [1:0] AB_EMPTY    = 2'd1;
  localparam logic [1:0] AB_OVERFLOW = 2'd2;

  // one classified input beat
  typedef struct packed {
    logic       is_end;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_newline;
    logic       is_colon;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [NUM_W-1:0]  value;
    logic              is_weight;
    logic [LINE_W-1:0] line_index;
    logic              end_of_line;
    logic [2:0]        status;
    logic              final_res;
  } res_t;

endpackage

// ===== rtl/atpc_front.sv =====
// front stage: accepts input beats and classifies the byte
// depends on atpc_pkg
`timescale 1ns / 1ps

module atpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [7:0]          ch,
  output logic                push_valid,
  input  logic                push_ready,
  output atpc_pkg::item_t     push_item
);

  logic            f_valid;
  logic            f_valid_next;
  atpc_pkg::item_t f_item;
  atpc_pkg::item_t cls;
  logic            take;
  logic [7:0]      ch_off;

  assign in_ready = !f_valid || push_ready;
  assign take     = in_valid && in_ready;
  assign ch_off   = ch - atpc_pkg::CH_ZERO;

  always_comb begin
    cls.is_end     = (kind == atpc_pkg::KIND_END);
    cls.is_digit   = (ch >= atpc_pkg::CH_ZERO) && (ch <= atpc_pkg::CH_NINE);
    cls.digit      = ch_off[3:0];
    cls.is_newline = (ch == atpc_pkg::CH_NEWLINE);
    cls.is_colon   = (ch == atpc_pkg::CH_COLON);
  end

  always_comb begin
    if (take) begin
      f_valid_next = 1'b1;
    end else if (push_ready) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_item <= cls;
    end
  end

  assign push_valid = f_valid;
  assign push_item  = f_item;

endmodule

// ===== rtl/atpc_queue.sv =====
// short queue of classified beats between front and back
// depends on atpc_pkg
`timescale 1ns / 1ps

module atpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  atpc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output atpc_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(atpc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(atpc_pkg::QUEUE_DEPTH + 1);

  atpc_pkg::item_t  slots [atpc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(atpc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(atpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(atpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/atpc_back.sv =====
// back stage: number assembly, line checks, verdict and output register
// depends on atpc_pkg
`timescale 1ns / 1ps

module atpc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  atpc_pkg::item_t                   q_item,
  output logic                              q_pop,
  input  logic                              weighted,
  input  logic [atpc_pkg::LINE_W-1:0]       node_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output atpc_pkg::res_t                    res
);

  localparam int unsigned NUM_W  = atpc_pkg::NUM_W;
  localparam int unsigned LINE_W = atpc_pkg::LINE_W;
  localparam int unsigned CNT_W  = atpc_pkg::CNT_W;
  localparam int unsigned PROD_W = NUM_W + 4;

  // running state
  logic [NUM_W-1:0]  number_accum,       number_accum_next;
  logic              digits_seen,        digits_seen_next;
  logic              overflow_seen,      overflow_seen_next;
  logic              weight_pending,     weight_pending_next;
  logic [LINE_W-1:0] current_line,       current_line_next;
  logic [CNT_W-1:0]  entries_in_line,    entries_in_line_next;
  logic [CNT_W-1:0]  weights_in_line,    weights_in_line_next;
  logic [NUM_W-1:0]  previous_neighbour, previous_neighbour_next;
  logic [1:0]        parse_aborted,      parse_aborted_next;
  logic [2:0]        first_invalid,      first_invalid_next;
  logic [2:0]        line_error,         line_error_next;

  logic              out_valid_next;
  logic              has_res;
  atpc_pkg::res_t    res_c;
  logic [LINE_W-1:0] limit;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  val;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign limit = (node_count > atpc_pkg::NODE_CAP) ? atpc_pkg::NODE_CAP : node_count;
  assign prod  = ({4'b0, number_accum} * PROD_W'(10)) + PROD_W'(q_item.digit);
  assign val   = number_accum;

  always_comb begin
    number_accum_next       = number_accum;
    digits_seen_next        = digits_seen;
    overflow_seen_next      = overflow_seen;
    weight_pending_next     = weight_pending;
    current_line_next       = current_line;
    entries_in_line_next    = entries_in_line;
    weights_in_line_next    = weights_in_line;
    previous_neighbour_next = previous_neighbour;
    parse_aborted_next      = parse_aborted;
    first_invalid_next      = first_invalid;
    line_error_next         = line_error;
    has_res                 = 1'b0;
    res_c                   = '0;

    if (q_item.is_end) begin
      has_res          = 1'b1;
      res_c.final_res  = 1'b1;
      res_c.line_index = current_line;
      if (parse_aborted != atpc_pkg::AB_NONE) begin
        res_c.status = {1'b0, parse_aborted};
      end else if (first_invalid != atpc_pkg::ST_OK) begin
        res_c.status = first_invalid;
      end else if (current_line != limit) begin
        res_c.status = atpc_pkg::ST_LINES;
      end else begin
        res_c.status = atpc_pkg::ST_OK;
      end
      number_accum_next       = '0;
      digits_seen_next        = 1'b0;
      overflow_seen_next      = 1'b0;
      weight_pending_next     = 1'b0;
      current_line_next       = '0;
      entries_in_line_next    = '0;
      weights_in_line_next    = '0;
      previous_neighbour_next = '0;
      parse_aborted_next      = atpc_pkg::AB_NONE;
      first_invalid_next      = atpc_pkg::ST_OK;
      line_error_next         = atpc_pkg::ST_OK;
    end else if (parse_aborted != atpc_pkg::AB_NONE) begin
      has_res = 1'b0;
    end else if (q_item.is_digit) begin
      if (prod > PROD_W'(atpc_pkg::NUM_MAX)) begin
        overflow_seen_next = 1'b1;
        number_accum_next  = atpc_pkg::NUM_MAX;
      end else begin
        number_accum_next = prod[NUM_W-1:0];
      end
      digits_seen_next = 1'b1;
    end else if (!digits_seen || overflow_seen) begin
      parse_aborted_next = digits_seen ? atpc_pkg::AB_OVERFLOW : atpc_pkg::AB_EMPTY;
      has_res            = 1'b1;
      res_c.is_weight    = weight_pending;
      res_c.line_index   = current_line;
      res_c.end_of_line  = q_item.is_newline;
      res_c.status       = {1'b0, parse_aborted_next};
    end else begin
      has_res           = 1'b1;
      res_c.value       = val;
      res_c.is_weight   = weight_pending;
      res_c.line_index  = current_line;
      res_c.end_of_line = q_item.is_newline;
      number_accum_next = '0;
      digits_seen_next  = 1'b0;

      if (weight_pending) begin
        if (weights_in_line != atpc_pkg::CNT_MAX) begin
          weights_in_line_next = weights_in_line + CNT_W'(1);
        end
        weight_pending_next = 1'b0;
      end else begin
        if (entries_in_line == '0) begin
          if (val != NUM_W'(current_line) && line_error_next == atpc_pkg::ST_OK) begin
            line_error_next = atpc_pkg::ST_FIRST;
          end
        end else begin
          if (val >= NUM_W'(limit)) begin
            if (line_error_next == atpc_pkg::ST_OK) begin
              line_error_next = atpc_pkg::ST_RANGE;
            end
          end else if (val < previous_neighbour) begin
            if (line_error_next == atpc_pkg::ST_OK) begin
              line_error_next = atpc_pkg::ST_DECREASE;
            end
          end
          previous_neighbour_next = val;
        end
        if (entries_in_line != atpc_pkg::CNT_MAX) begin
          entries_in_line_next = entries_in_line + CNT_W'(1);
        end
      end

      if (q_item.is_newline) begin
        if (entries_in_line_next == '0) begin
          if (line_error_next == atpc_pkg::ST_OK) begin
            line_error_next = atpc_pkg::ST_FIRST;
          end
        end else if (weighted &&
                     weights_in_line_next != entries_in_line_next - CNT_W'(1)) begin
          if (line_error_next == atpc_pkg::ST_OK) begin
            line_error_next = atpc_pkg::ST_WEIGHTS;
          end
        end
        if (first_invalid_next == atpc_pkg::ST_OK) begin
          first_invalid_next = line_error_next;
        end
        line_error_next         = atpc_pkg::ST_OK;
        entries_in_line_next    = '0;
        weights_in_line_next    = '0;
        previous_neighbour_next = '0;
        weight_pending_next     = 1'b0;
        if (current_line != atpc_pkg::LINE_MAX) begin
          current_line_next = current_line + LINE_W'(1);
        end
      end

      if (q_item.is_colon) begin
        weight_pending_next = 1'b1;
      end

      res_c.status = (first_invalid_next != atpc_pkg::ST_OK) ? first_invalid_next :
                     line_error_next;
    end
  end

  always_comb begin
    if (q_pop && has_res) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      number_accum       <= '0;
      digits_seen        <= 1'b0;
      overflow_seen      <= 1'b0;
      weight_pending     <= 1'b0;
      current_line       <= '0;
      entries_in_line    <= '0;
      weights_in_line    <= '0;
      previous_neighbour <= '0;
      parse_aborted      <= atpc_pkg::AB_NONE;
      first_invalid      <= atpc_pkg::ST_OK;
      line_error         <= atpc_pkg::ST_OK;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        number_accum       <= number_accum_next;
        digits_seen        <= digits_seen_next;
        overflow_seen      <= overflow_seen_next;
        weight_pending     <= weight_pending_next;
        current_line       <= current_line_next;
        entries_in_line    <= entries_in_line_next;
        weights_in_line    <= weights_in_line_next;
        previous_neighbour <= previous_neighbour_next;
        parse_aborted      <= parse_aborted_next;
        first_invalid      <= first_invalid_next;
        line_error         <= line_error_next;
      end
    end
  end

  // result payload, loaded only when a new beat is produced
  always_ff @(posedge clk) begin
    if (q_pop && has_res) begin
      res <= res_c;
    end
  end

endmodule

// ===== rtl/adjacency_text_parser_checker.sv =====
// top level of the adjacency list text checker: config registers, front, queue, back
// depends on atpc_pkg, atpc_front, atpc_queue, atpc_back and the defines header
//
//   channel   handshake              payload
//   input     in_valid / in_ready    kind, ch
//   result    out_valid / out_ready  value, is_weight, line_index, end_of_line,
//                                    status, final_res
//   config    wr_en (no wait)        wr_index, wr_data
//
// one beat per cycle sustained while the result channel does not stall; a byte that yields a
// result passes the front register and a queue slot before the back stage loads the result register
// the rate is set by the back stage, which folds one byte a cycle, unless the result is stalled,
// into the running state (accumulate times ten, line checks) in a single step
// rst is synchronous; it clears the config registers, the queue and all parse state
// a stalled result holds the back stage; the two-slot queue and the front register
// keep accepting until they fill, so each side stalls on its own
`timescale 1ns / 1ps
`include "adjacency_text_parser_checker_defines.svh"

module adjacency_text_parser_checker (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [7:0]                    ch,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [atpc_pkg::NUM_W-1:0]    value,
  output logic                          is_weight,
  output logic [atpc_pkg::LINE_W-1:0]   line_index,
  output logic                          end_of_line,
  output logic [2:0]                    status,
  output logic                          final_res,
  // configuration write port
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [atpc_pkg::LINE_W-1:0]   wr_data
);

  // configuration; the user must write it only while idle, the block does not enforce this
  logic                        weighted;
  logic [atpc_pkg::LINE_W-1:0] node_count;

  // front to queue
  logic            push_valid;
  logic            push_ready;
  atpc_pkg::item_t push_item;

  // queue to back
  logic            q_valid;
  logic            q_pop;
  atpc_pkg::item_t q_item;

  // result beat from the back output register
  atpc_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted   <= 1'b0;
      node_count <= '0;
    end else if (wr_en) begin
      case (wr_index)
        atpc_pkg::REG_WEIGHTED:   weighted   <= wr_data[0];
        atpc_pkg::REG_NODE_COUNT: node_count <= wr_data;
        default:                  weighted   <= weighted;
      endcase
    end
  end

  // front: takes a byte, flags digit, newline, colon and end
  atpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .ch         (ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // two-slot queue decouples the front from the back
  atpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back: number assembly, per-line checks, verdict, output register
  atpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .weighted   (weighted),
    .node_count (node_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign value       = res.value;
  assign is_weight   = res.is_weight;
  assign line_index  = res.line_index;
  assign end_of_line = res.end_of_line;
  assign status      = res.status;
  assign final_res   = res.final_res;

  // the verdict carries no number, no weight flag and no newline flag
  `ATPC_ASSERT_NOW(a_final_clean, clk, rst, out_valid && final_res, value == '0 && !is_weight && !end_of_line)

  // an abort beat carries no number
  `ATPC_ASSERT_NOW(a_abort_zero, clk, rst, out_valid && !final_res && (status == atpc_pkg::ST_EMPTY || status == atpc_pkg::ST_OVERFLOW), value == '0)

  // a line count error shows up only in the verdict
  `ATPC_ASSERT_NOW(a_lines_final, clk, rst, out_valid && status == atpc_pkg::ST_LINES, final_res)

  // the back never pops an empty queue
  `ATPC_ASSERT_NOW(a_pop_valid, clk, rst, q_pop, q_valid)

  // a beat pushed into an empty queue is visible to the back next cycle
  `ATPC_ASSERT_NEXT(a_queue_fill, clk, rst, push_valid && push_ready, q_valid)

endmodule
